@@ design/feic_pkg.sv @@
`timescale 1ns / 1ps
package feic_pkg;
  localparam int unsigned MAX_EXTENTS_DEF  = 64;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  typedef enum logic [2:0] {
    ST_NEW    = 3'd0,
    ST_LOWER  = 3'd1,
    ST_UPPER  = 3'd2,
    ST_BOTH   = 3'd3,
    ST_NULL   = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } fsm_t;
endpackage

@@ design/feic_mem.sv @@
`timescale 1ns / 1ps
// One-port-write, one-port-read extent store, registered read data.
module feic_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/free_extent_insert_coalesce_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                    Handshake
// input     in_block_addr, in_block_size             start & !busy
// result    out_status, out_extent_start,            out_valid, one cycle,
//           out_extent_size, out_extents_held        cannot be held off
//
// An item runs from acceptance through the scan and any shift to the result
// strobe; a null address goes straight to the result. The single read port
// of the extent memory sets the pace: the scan reads then compares each entry,
// then an insert or a double merge moves the tail one entry at a time (read, write).
// Reset (rst_n low, synchronous) empties the table; memory contents are not
// cleared, entries at or above the count are never read.
// busy stays high from acceptance through the result strobe cycle.
module free_extent_insert_coalesce_unit #(
  parameter int unsigned MAX_EXTENTS  = feic_pkg::MAX_EXTENTS_DEF,
  parameter int unsigned HEADER_BYTES = feic_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_block_addr,
  input  logic [31:0] in_block_size,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_extent_start,
  output logic [31:0] out_extent_size,
  output logic [6:0]  out_extents_held
);
  import feic_pkg::*;

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);

  fsm_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;     // scan index
  logic [CW-1:0] mv_r, mv_nxt;       // shift cursor
  logic [31:0]   addr_r, size_r;
  logic [31:0]   prev_s_r, prev_l_r, prev_s_nxt, prev_l_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [31:0]   cur_s_r, cur_l_r, cur_s_nxt, cur_l_nxt;
  logic          have_cur_r, have_cur_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [63:0]   carry_r, carry_nxt;   // entry displaced during insert shift
  logic          ins_r, ins_nxt;       // 1 insert shift up, 0 delete shift down
  logic [2:0]    st_r, st_nxt;
  logic [31:0]   rs_r, rz_r, rs_nxt, rz_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  feic_mem #(.DEPTH(MAX_EXTENTS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic lo, hi;
  assign lo = have_prev_r && ((addr_r - prev_s_r - prev_l_r) == HDR);
  assign hi = have_cur_r && ((cur_s_r - addr_r - size_r) == HDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    pos_r <= pos_nxt; mv_r <= mv_nxt;
    prev_s_r <= prev_s_nxt; prev_l_r <= prev_l_nxt; have_prev_r <= have_prev_nxt;
    cur_s_r <= cur_s_nxt; cur_l_r <= cur_l_nxt; have_cur_r <= have_cur_nxt;
    carry_r <= carry_nxt; ins_r <= ins_nxt; st_r <= st_nxt;
    rs_r <= rs_nxt; rz_r <= rz_nxt;
    if (start && !busy) begin
      addr_r <= in_block_addr;
      size_r <= in_block_size;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = (in_block_addr == '0) ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (rd_pend_r && rdata[63:32] > addr_r) state_nxt = S_DECIDE;
        else if (!rd_pend_r && pos_r >= count_r) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (lo && hi) state_nxt = S_SHIFT;
        else if (lo || hi) state_nxt = S_DONE;
        else if (count_r >= CW'(MAX_EXTENTS)) state_nxt = S_DONE;
        else state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (ins_r) begin
          if (mv_r >= count_r) state_nxt = S_DONE;
        end else if (CW'(mv_r + 1'b1) >= count_r && !rd_pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt = count_r; pos_nxt = pos_r; mv_nxt = mv_r;
    prev_s_nxt = prev_s_r; prev_l_nxt = prev_l_r; have_prev_nxt = have_prev_r;
    cur_s_nxt = cur_s_r; cur_l_nxt = cur_l_r; have_cur_nxt = have_cur_r;
    rd_pend_nxt = 1'b0; carry_nxt = carry_r; ins_nxt = ins_r;
    st_nxt = st_r; rs_nxt = rs_r; rz_nxt = rz_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    case (state_r)
      S_IDLE: begin
        pos_nxt = '0; have_prev_nxt = 1'b0; have_cur_nxt = 1'b0;
        st_nxt = ST_NULL; rs_nxt = '0; rz_nxt = '0;
      end
      S_SCAN: begin
        if (rd_pend_r) begin
          if (rdata[63:32] > addr_r) begin
            cur_s_nxt = rdata[63:32]; cur_l_nxt = rdata[31:0];
            have_cur_nxt = 1'b1;
          end else begin
            prev_s_nxt = rdata[63:32]; prev_l_nxt = rdata[31:0];
            have_prev_nxt = 1'b1;
            pos_nxt = CW'(pos_r + 1'b1);
          end
        end else if (pos_r < count_r) begin
          raddr = pos_r[AW-1:0];
          rd_pend_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        if (lo && hi) begin
          we = 1'b1; waddr = AW'(pos_r - 1'b1);
          rs_nxt = prev_s_r;
          rz_nxt = prev_l_r + size_r + cur_l_r + (HDR << 1);
          wdata = {prev_s_r, rz_nxt};
          st_nxt = ST_BOTH; ins_nxt = 1'b0; mv_nxt = pos_r;
        end else if (lo) begin
          we = 1'b1; waddr = AW'(pos_r - 1'b1);
          rs_nxt = prev_s_r; rz_nxt = prev_l_r + size_r + HDR;
          wdata = {prev_s_r, rz_nxt}; st_nxt = ST_LOWER;
        end else if (hi) begin
          we = 1'b1; waddr = pos_r[AW-1:0];
          rs_nxt = addr_r; rz_nxt = size_r + cur_l_r + HDR;
          wdata = {addr_r, rz_nxt}; st_nxt = ST_UPPER;
        end else if (count_r >= CW'(MAX_EXTENTS)) begin
          st_nxt = ST_FULL;
        end else begin
          rs_nxt = addr_r; rz_nxt = size_r; st_nxt = ST_NEW;
          ins_nxt = 1'b1; mv_nxt = pos_r;
          carry_nxt = {addr_r, size_r};
        end
      end
      S_SHIFT: begin
        if (ins_r) begin
          // write carry at mv, the displaced entry becomes the next carry
          if (mv_r < count_r) begin
            if (!rd_pend_r) begin
              raddr = mv_r[AW-1:0]; rd_pend_nxt = 1'b1;
            end else begin
              we = 1'b1; waddr = mv_r[AW-1:0]; wdata = carry_r;
              carry_nxt = rdata; mv_nxt = CW'(mv_r + 1'b1);
            end
          end else begin
            we = 1'b1; waddr = mv_r[AW-1:0]; wdata = carry_r;
            count_nxt = CW'(count_r + 1'b1);
          end
        end else begin
          // delete entry at mv: move mv+1 down
          if (CW'(mv_r + 1'b1) < count_r) begin
            if (!rd_pend_r) begin
              raddr = AW'(mv_r + 1'b1); rd_pend_nxt = 1'b1;
            end else begin
              we = 1'b1; waddr = mv_r[AW-1:0]; wdata = rdata;
              mv_nxt = CW'(mv_r + 1'b1);
            end
          end else begin
            count_nxt = CW'(count_r - 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_status = st_r;
    out_extent_start = rs_r;
    out_extent_size = rz_r;
    out_extents_held = 7'(count_r);
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EXTENTS)) else $error("extent count over capacity");
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_full_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NULL))
      |-> $stable(count_r)) else $error("count moved on drop");
`endif
endmodule
